>>> src/fdbt_pkg.sv
package fdbt_pkg;

   localparam int PAGE_BYTES_LOG2 = 12;
   localparam int MAX_DIM = 4096;

   localparam int PAGE_W = 14;
   localparam int DIM_W = $clog2(MAX_DIM) + 1;
   localparam int FMT_W = 2;
   localparam int LINE_W = DIM_W + 2;
   localparam int DIVIDEND_W = PAGE_W + PAGE_BYTES_LOG2;
   localparam int DIV_CNT_W = $clog2(DIVIDEND_W);
   localparam int CSR_INDEX_W = 2;

   localparam int RECIP3_SHIFT = 17;
   localparam int PROD_W = LINE_W + RECIP3_SHIFT;
   localparam int RECIP3 = ((1 << RECIP3_SHIFT) + 2) / 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_PAGE_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT = 2'd2;

   localparam logic [FMT_W-1:0] FMT_16BPP = 2'd0;
   localparam logic [FMT_W-1:0] FMT_24BPP = 2'd1;
   localparam logic [FMT_W-1:0] FMT_32BPP = 2'd2;

   localparam logic [DIM_W-1:0] RESET_WIDTH = DIM_W'(1024);
   localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(768);

   typedef struct packed {
      logic              opcode;
      logic [PAGE_W-1:0] page_number;
   } item_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [LINE_W-1:0]     remainder;
   } div_result_type;

   function automatic logic [2:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
      logic [2:0] bpp;
      case (fmt)
         FMT_16BPP: bpp = 3'd2;
         FMT_24BPP: bpp = 3'd3;
         default:   bpp = 3'd4;
      endcase
      return bpp;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value);
      logic [DIM_W-1:0] result;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (value > DIM_W'(MAX_DIM)) begin
         result = DIM_W'(MAX_DIM);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

>>> src/fdbt_front.sv
module fdbt_front
   import fdbt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [PAGE_W-1:0] req_page_number,
   output logic              q_valid,
   output item_type          q_item,
   input  logic              q_pop
);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push;
   item_type              new_item;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (count_ff != '0);
   assign q_item = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.opcode = req_opcode;
      new_item.page_number = req_page_number;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> src/fdbt_divider.sv
module fdbt_divider
   import fdbt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [LINE_W-1:0]     divisor,
   output div_result_type        result
);

   logic [LINE_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [LINE_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [LINE_W:0]       trial;
   logic [LINE_W:0]       diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff = trial - {1'b0, divisor_ff};
   assign fits = (trial >= {1'b0, divisor_ff});

   assign result.done = done_ff;
   assign result.quotient = quo_ff;
   assign result.remainder = rem_ff;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      divisor_in = divisor_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         divisor_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[LINE_W-1:0] : trial[LINE_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      divisor_ff <= divisor_in;
   end

endmodule

>>> src/fdbt_back.sv
module fdbt_back
   import fdbt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  item_type               q_item,
   output logic                   q_pop,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_box_present,
   output logic [DIM_W-1:0]       rsp_left_col,
   output logic [DIM_W-1:0]       rsp_top_row,
   output logic [DIM_W-1:0]       rsp_right_col,
   output logic [DIM_W-1:0]       rsp_bottom_row
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_COL  = 4'b0100,
      ST_UPD  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [FMT_W-1:0]   fmt_ff, fmt_in;
   logic               box_valid_ff, box_valid_in;
   logic [DIM_W-1:0]   box_left_ff, box_left_in;
   logic [DIM_W-1:0]   box_top_ff, box_top_in;
   logic [DIM_W-1:0]   box_right_ff, box_right_in;
   logic [DIM_W-1:0]   box_bottom_ff, box_bottom_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               row_ok_ff, row_ok_in;
   logic [DIM_W-1:0]   row_ff, row_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_present_ff, rsp_present_in;
   logic [DIM_W-1:0]   rsp_left_ff, rsp_left_in;
   logic [DIM_W-1:0]   rsp_top_ff, rsp_top_in;
   logic [DIM_W-1:0]   rsp_right_ff, rsp_right_in;
   logic [DIM_W-1:0]   rsp_bottom_ff, rsp_bottom_in;
   logic               div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [LINE_W-1:0]  div_divisor;
   div_result_type     div_result;
   logic               rsp_free;
   logic [LINE_W-1:0]  col_wide;
   logic [DIM_W-1:0]   col;
   logic [DIM_W-1:0]   col_end;
   logic [DIM_W-1:0]   row_end;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign div_dividend = {q_item.page_number, PAGE_BYTES_LOG2'(0)};
   assign div_divisor = LINE_W'({2'b00, width_ff} * LINE_W'(bytes_per_pixel(fmt_ff)));

   fdbt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_result)
   );

   always_comb begin
      case (fmt_ff)
         FMT_16BPP: col_wide = div_result.remainder >> 1;
         FMT_24BPP: col_wide = prod_ff[PROD_W-1:RECIP3_SHIFT];
         default:   col_wide = div_result.remainder >> 2;
      endcase
      col = col_wide[DIM_W-1:0];
      col_end = col + 1'b1;
      row_end = row_ff + 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      q_pop = 1'b0;
      div_start = 1'b0;
      width_in = width_ff;
      height_in = height_ff;
      fmt_in = fmt_ff;
      box_valid_in = box_valid_ff;
      box_left_in = box_left_ff;
      box_top_in = box_top_ff;
      box_right_in = box_right_ff;
      box_bottom_in = box_bottom_ff;
      prod_in = prod_ff;
      row_ok_in = row_ok_ff;
      row_in = row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_present_in = rsp_present_ff;
      rsp_left_in = rsp_left_ff;
      rsp_top_in = rsp_top_ff;
      rsp_right_in = rsp_right_ff;
      rsp_bottom_in = rsp_bottom_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.opcode == OP_QUERY) begin
                  if (rsp_free) begin
                     q_pop = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_present_in = box_valid_ff;
                     rsp_left_in = box_valid_ff ? box_left_ff : '0;
                     rsp_top_in = box_valid_ff ? box_top_ff : '0;
                     rsp_right_in = box_valid_ff ? box_right_ff : '0;
                     rsp_bottom_in = box_valid_ff ? box_bottom_ff : '0;
                     box_valid_in = 1'b0;
                  end
               end else begin
                  q_pop = 1'b1;
                  div_start = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_result.done) begin
               state_in = ST_COL;
            end
         end
         ST_COL: begin
            prod_in = PROD_W'(div_result.remainder) * PROD_W'(RECIP3);
            row_ok_in = (div_result.quotient < DIVIDEND_W'(height_ff));
            row_in = div_result.quotient[DIM_W-1:0];
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (row_ok_ff) begin
               if (!box_valid_ff) begin
                  box_valid_in = 1'b1;
                  box_left_in = col;
                  box_top_in = row_ff;
                  box_right_in = col_end;
                  box_bottom_in = row_end;
               end else begin
                  if (col < box_left_ff) begin
                     box_left_in = col;
                  end
                  if (row_ff < box_top_ff) begin
                     box_top_in = row_ff;
                  end
                  if (col_end > box_right_ff) begin
                     box_right_in = col_end;
                  end
                  if (row_end > box_bottom_ff) begin
                     box_bottom_in = row_end;
                  end
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = clamp_dim(csr_write_data);
               box_valid_in = 1'b0;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = clamp_dim(csr_write_data);
               box_valid_in = 1'b0;
            end
            CSR_PIXEL_FORMAT: begin
               fmt_in = (csr_write_data[FMT_W-1:0] > FMT_32BPP) ? FMT_32BPP
                                                                : csr_write_data[FMT_W-1:0];
               box_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         fmt_ff <= FMT_32BPP;
         box_valid_ff <= 1'b0;
         box_left_ff <= '0;
         box_top_ff <= '0;
         box_right_ff <= '0;
         box_bottom_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         height_ff <= height_in;
         fmt_ff <= fmt_in;
         box_valid_ff <= box_valid_in;
         box_left_ff <= box_left_in;
         box_top_ff <= box_top_in;
         box_right_ff <= box_right_in;
         box_bottom_ff <= box_bottom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      row_ok_ff <= row_ok_in;
      row_ff <= row_in;
      rsp_present_ff <= rsp_present_in;
      rsp_left_ff <= rsp_left_in;
      rsp_top_ff <= rsp_top_in;
      rsp_right_ff <= rsp_right_in;
      rsp_bottom_ff <= rsp_bottom_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_box_present = rsp_present_ff;
   assign rsp_left_col = rsp_left_ff;
   assign rsp_top_row = rsp_top_ff;
   assign rsp_right_col = rsp_right_ff;
   assign rsp_bottom_row = rsp_bottom_ff;

endmodule

>>> src/framebuffer_dirty_box_tracker_unit.sv
// Dirty bounding-box tracker for a packed-pixel framebuffer.
// The request channel (req_) carries an opcode and a page number. A page-write
// transfer widens the dirty box to cover the first pixel of that page if its row
// is in the frame. A query gives one response (rsp_) with the box and clears it.
// A two-entry queue sits between the request side and the execution side, so
// requests are taken while the execution side works or the response waits.
// A page write passes through the execution side: the row comes from
// a restoring divider by the line length that yields one quotient bit per
// cycle over the 26-bit byte offset, followed by a column step and an update.
// A query's response is registered, appearing in the cycle after it leaves the
// queue. Writes through the csr_ port set width, height and pixel format
// and clear the box; they are expected only while the block is idle.
// Reset empties the queue, drops any response and clears the box, and the
// configuration returns to 1024 by 768 at 32 bits per pixel.
// While rsp_stall is high the response register holds; queries then wait in
// the queue, and req_stall rises once the queue is full.
module framebuffer_dirty_box_tracker_unit
   import fdbt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic [PAGE_W-1:0]      req_page_number,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_box_present,
   output logic [DIM_W-1:0]       rsp_left_col,
   output logic [DIM_W-1:0]       rsp_top_row,
   output logic [DIM_W-1:0]       rsp_right_col,
   output logic [DIM_W-1:0]       rsp_bottom_row,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   fdbt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_page_number (req_page_number),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   fdbt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_box_present  (rsp_box_present),
      .rsp_left_col     (rsp_left_col),
      .rsp_top_row      (rsp_top_row),
      .rsp_right_col    (rsp_right_col),
      .rsp_bottom_row   (rsp_bottom_row)
   );

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("Queue popped while empty.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_box_present) |->
         (rsp_left_col == '0 && rsp_top_row == '0 &&
          rsp_right_col == '0 && rsp_bottom_row == '0))
      else $error("Empty box response carries nonzero coordinates.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_box_present) |->
         (rsp_right_col > rsp_left_col && rsp_bottom_row > rsp_top_row))
      else $error("Dirty box response has inverted bounds.");

   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

>>> dv/tb_framebuffer_dirty_box_tracker_unit.sv
`timescale 1ns / 1ps

module tb_framebuffer_dirty_box_tracker_unit
   import fdbt_pkg::*;
();

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [FMT_W-1:0] FMT_RESERVED = 2'd3;
   localparam int DRAIN_CYCLES = 120;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct packed {
      logic             present;
      logic [DIM_W-1:0] left_col;
      logic [DIM_W-1:0] top_row;
      logic [DIM_W-1:0] right_col;
      logic [DIM_W-1:0] bottom_row;
   } box_report_type;

   typedef enum logic [1:0] {ROW_PAGE, ROW_QUERY, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  idx;
      logic [PAGE_W-1:0]       value;
      logic                    checked;
      box_report_type          want;
   } plan_row_type;

   localparam box_report_type NO_BOX = '0;

   localparam plan_row_type DIRECTED_PLAN [35] = '{
      '{ROW_QUERY, '0, 14'd0, 1'b1, NO_BOX},
      '{ROW_PAGE, '0, 14'd0, 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd767, 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd768, 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd16383, 1'b0, NO_BOX},
      '{ROW_QUERY, '0, 14'd0, 1'b1, '{1'b1, 13'd0, 13'd0, 13'd1, 13'd768}},
      '{ROW_QUERY, '0, 14'd16383, 1'b1, NO_BOX},
      '{ROW_CSR, CSR_FRAME_WIDTH, 14'd0, 1'b0, NO_BOX},
      '{ROW_CSR, CSR_FRAME_HEIGHT, 14'd0, 1'b0, NO_BOX},
      '{ROW_CSR, CSR_PIXEL_FORMAT, 14'(FMT_16BPP), 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd0, 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd1, 1'b0, NO_BOX},
      '{ROW_QUERY, '0, 14'd0, 1'b1, '{1'b1, 13'd0, 13'd0, 13'd1, 13'd1}},
      '{ROW_CSR, CSR_FRAME_WIDTH, 14'd8191, 1'b0, NO_BOX},
      '{ROW_CSR, CSR_FRAME_HEIGHT, 14'd8191, 1'b0, NO_BOX},
      '{ROW_CSR, CSR_PIXEL_FORMAT, 14'(FMT_RESERVED), 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd16383, 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd0, 1'b0, NO_BOX},
      '{ROW_QUERY, '0, 14'd0, 1'b1, '{1'b1, 13'd0, 13'd0, 13'd3073, 13'd4096}},
      '{ROW_CSR, CSR_PIXEL_FORMAT, 14'(FMT_24BPP), 1'b0, NO_BOX},
      '{ROW_CSR, CSR_FRAME_WIDTH, 14'd1000, 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd1, 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd5, 1'b0, NO_BOX},
      '{ROW_QUERY, '0, 14'd0, 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd0, 1'b0, NO_BOX},
      '{ROW_CSR, CSR_FRAME_WIDTH, 14'd1024, 1'b0, NO_BOX},
      '{ROW_QUERY, '0, 14'd0, 1'b1, NO_BOX},
      '{ROW_PAGE, '0, 14'd2, 1'b0, NO_BOX},
      '{ROW_CSR, CSR_UNUSED, 14'd8191, 1'b0, NO_BOX},
      '{ROW_QUERY, '0, 14'd0, 1'b0, NO_BOX},
      '{ROW_CSR, CSR_FRAME_WIDTH, 14'd4095, 1'b0, NO_BOX},
      '{ROW_CSR, CSR_PIXEL_FORMAT, 14'(FMT_16BPP), 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd12345, 1'b0, NO_BOX},
      '{ROW_PAGE, '0, 14'd4097, 1'b0, NO_BOX},
      '{ROW_QUERY, '0, 14'd0, 1'b0, NO_BOX}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = OP_PAGE_WRITE;
   logic [PAGE_W-1:0] req_page_number = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_box_present;
   logic [DIM_W-1:0] rsp_left_col;
   logic [DIM_W-1:0] rsp_top_row;
   logic [DIM_W-1:0] rsp_right_col;
   logic [DIM_W-1:0] rsp_bottom_row;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0] csr_write_data = '0;

   logic [DIM_W-1:0] model_width = RESET_WIDTH;
   logic [DIM_W-1:0] model_height = RESET_HEIGHT;
   logic [FMT_W-1:0] fb_format = FMT_32BPP;
   box_report_type dirty_box = NO_BOX;
   box_report_type expected_boxes [$];

   int error_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   logic [1:0] stall_mode = 2'd0;
   int stall_run = 0;

   framebuffer_dirty_box_tracker_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_box_present  (rsp_box_present),
      .rsp_left_col     (rsp_left_col),
      .rsp_top_row      (rsp_top_row),
      .rsp_right_col    (rsp_right_col),
      .rsp_bottom_row   (rsp_bottom_row),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [2:0] bpp_of(input logic [FMT_W-1:0] fmt);
      case (fmt)
         FMT_16BPP: return 3'd2;
         FMT_24BPP: return 3'd3;
         default:   return 3'd4;
      endcase
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [DIM_W-1:0] value);
      logic [DIM_W-1:0] dim;
      if (value == '0) begin
         dim = DIM_W'(1);
      end else if (value > DIM_W'(MAX_DIM)) begin
         dim = DIM_W'(MAX_DIM);
      end else begin
         dim = value;
      end
      case (idx)
         CSR_FRAME_WIDTH:  model_width = dim;
         CSR_FRAME_HEIGHT: model_height = dim;
         CSR_PIXEL_FORMAT: begin
            fb_format = (value[FMT_W-1:0] == FMT_RESERVED) ? FMT_32BPP : value[FMT_W-1:0];
         end
         default: ;
      endcase
      if (idx != CSR_UNUSED) begin
         dirty_box.present = 1'b0;
      end
   endfunction

   function automatic void mark_page(input logic [PAGE_W-1:0] page);
      logic [2:0] bpp;
      logic [LINE_W-1:0] line_bytes;
      logic [DIVIDEND_W-1:0] offset;
      logic [DIVIDEND_W-1:0] row;
      logic [DIM_W-1:0] col;
      bpp = bpp_of(fb_format);
      line_bytes = LINE_W'(model_width) * LINE_W'(bpp);
      offset = DIVIDEND_W'(page) << PAGE_BYTES_LOG2;
      row = offset / line_bytes;
      if (row >= DIVIDEND_W'(model_height)) begin
         return;
      end
      col = DIM_W'((offset - row * line_bytes) / bpp);
      if (!dirty_box.present) begin
         dirty_box = '{1'b1, col, DIM_W'(row), col + 1'b1, DIM_W'(row) + 1'b1};
      end else begin
         if (col < dirty_box.left_col) dirty_box.left_col = col;
         if (DIM_W'(row) < dirty_box.top_row) dirty_box.top_row = DIM_W'(row);
         if (col + 1'b1 > dirty_box.right_col) dirty_box.right_col = col + 1'b1;
         if (DIM_W'(row) + 1'b1 > dirty_box.bottom_row) begin
            dirty_box.bottom_row = DIM_W'(row) + 1'b1;
         end
      end
   endfunction

   function automatic box_report_type report_box();
      box_report_type rep;
      rep = dirty_box.present ? dirty_box : NO_BOX;
      dirty_box.present = 1'b0;
      return rep;
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return DIM_W'(1);
         2:       return DIM_W'(MAX_DIM);
         3:       return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
         4:       return DIM_W'($urandom_range(1, 64));
         default: return DIM_W'($urandom_range(1, MAX_DIM));
      endcase
   endfunction

   task automatic send_request(input logic op, input logic [PAGE_W-1:0] page,
                               input logic checked, input box_report_type want);
      box_report_type rep;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_page_number <= page;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_PAGE_WRITE) begin
         mark_page(page);
      end else begin
         rep = report_box();
         expected_boxes.push_back(checked ? want : rep);
      end
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8))
            @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [DIM_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      apply_csr(idx, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_run <= $urandom_range(8, 64);
         end else begin
            stall_run <= stall_run - 1;
         end
         case (stall_mode)
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= 1'($urandom_range(0, 1));
            2'd2: rsp_stall <= ($urandom_range(0, 7) != 0);
            default: rsp_stall <= stall_run[2];
         endcase
      end
   end

   always @(posedge clock) begin
      box_report_type got;
      box_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_box_present, rsp_left_col, rsp_top_row, rsp_right_col, rsp_bottom_row};
         if (expected_boxes.size() == 0) begin
            if (error_count < 10) begin
               $display("ERROR: unexpected response present=%0d box=(%0d,%0d)-(%0d,%0d)",
                        got.present, got.left_col, got.top_row, got.right_col,
                        got.bottom_row);
            end
            error_count++;
         end else begin
            want = expected_boxes.pop_front();
            if (got.present !== want.present || got.left_col !== want.left_col ||
                got.top_row !== want.top_row || got.right_col !== want.right_col ||
                got.bottom_row !== want.bottom_row) begin
               if (error_count < 10) begin
                  $display("ERROR: box mismatch expected present=%0d (%0d,%0d)-(%0d,%0d)",
                           want.present, want.left_col, want.top_row, want.right_col,
                           want.bottom_row);
                  $display("       actual          present=%0d (%0d,%0d)-(%0d,%0d)",
                           got.present, got.left_col, got.top_row, got.right_col,
                           got.bottom_row);
               end
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic was_config;
      logic op;
      logic [PAGE_W-1:0] page;
      logic [DIM_W-1:0] new_width;
      logic [DIM_W-1:0] new_height;
      logic [FMT_W-1:0] new_format;
      int unsigned span;
      plan_row_type row;

      was_config = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIRECTED_PLAN); r++) begin
         row = DIRECTED_PLAN[r];
         if (row.kind == ROW_CSR) begin
            if (!was_config) settle();
            write_csr(row.idx, DIM_W'(row.value));
            was_config = 1'b1;
         end else begin
            send_request((row.kind == ROW_QUERY) ? OP_QUERY : OP_PAGE_WRITE, row.value,
                         row.checked, row.want);
            was_config = 1'b0;
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         if (phase == 0) begin
            new_width = DIM_W'(1);
            new_height = DIM_W'(1);
            new_format = FMT_16BPP;
         end else if (phase == 1) begin
            new_width = DIM_W'(MAX_DIM);
            new_height = DIM_W'(MAX_DIM);
            new_format = FMT_24BPP;
         end else begin
            new_width = pick_dim();
            new_height = pick_dim();
            new_format = FMT_W'($urandom_range(0, 3));
         end
         if (phase < 2 || $urandom_range(0, 2) != 0) write_csr(CSR_FRAME_WIDTH, new_width);
         if (phase < 2 || $urandom_range(0, 2) != 0) write_csr(CSR_FRAME_HEIGHT, new_height);
         if (phase < 2 || $urandom_range(0, 2) != 0) begin
            write_csr(CSR_PIXEL_FORMAT, DIM_W'(new_format));
         end
         if ($urandom_range(0, 2) == 0) write_csr(CSR_UNUSED, DIM_W'($urandom));

         span = (int'(model_height) * int'(model_width) * int'(bpp_of(fb_format)) +
                 (1 << PAGE_BYTES_LOG2) - 1) >> PAGE_BYTES_LOG2;
         if (span > (1 << PAGE_W)) span = 1 << PAGE_W;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) < 3) begin
               op = OP_QUERY;
               page = PAGE_W'($urandom);
            end else begin
               op = OP_PAGE_WRITE;
               if ($urandom_range(0, 3) != 0) begin
                  page = PAGE_W'($urandom_range(0, span - 1));
               end else begin
                  page = PAGE_W'($urandom);
               end
            end
            send_request(op, page, 1'b0, NO_BOX);
         end
      end

      settle();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
